// ===== hdl/lbet_pkg.sv =====
// shared types, codes and sizes for the led blink event table
package lbet_pkg;

    localparam int MAX_EVENTS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int RES_IDX_W      = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] FOREVER_REPEATS = 8'hFF;

    // request codes
    localparam logic [1:0] REQ_SETUP  = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_PARAM = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_PRIO_HELD = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // one stored blink event
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] on_time;
        logic [15:0] off_time;
        logic [7:0]  repeats;
        logic [7:0]  prio;
        logic [31:0] start;
        logic        lit;
    } entry_t;

    // outcome of one entry on a tick
    typedef struct packed {
        entry_t entry;
        logic   keep;
        logic   report;
        logic   drive_on;
    } step_t;

endpackage

// ===== hdl/lbet_entry_ram.sv =====
// entry memory: one write port, one read port, registered read data
module lbet_entry_ram #(
    parameter int DEPTH  = lbet_pkg::MAX_EVENTS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  lbet_pkg::entry_t      wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output lbet_pkg::entry_t      rd_data
);

    lbet_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/lbet_entry_step.sv =====
// per-tick timing update of one blink entry
module lbet_entry_step (
    input  lbet_pkg::entry_t entry,
    input  logic [31:0]      now,
    output lbet_pkg::step_t  step
);

    logic [31:0] elapsed;
    logic [31:0] start_on;
    logic [31:0] start_off;
    logic        on_done;
    logic        off_done;
    logic        endless;
    logic [7:0]  rep_dec;
    logic        relight;

    always_comb
    begin
        elapsed   = now - entry.start;
        start_on  = entry.start + {16'd0, entry.on_time};
        start_off = entry.start + {16'd0, entry.off_time};
        on_done   = elapsed > {16'd0, entry.on_time};
        off_done  = elapsed > {16'd0, entry.off_time};
        endless   = entry.repeats == lbet_pkg::FOREVER_REPEATS;
        rep_dec   = endless ? entry.repeats : entry.repeats - 8'd1;
        relight   = endless || (rep_dec != 8'd0);

        step          = '0;
        step.entry    = entry;
        step.keep     = 1'b1;

        if (entry.lit)
        begin
            if (on_done)
            begin
                step.entry.lit   = 1'b0;
                step.entry.start = start_on;
                step.report      = 1'b1;
                step.drive_on    = 1'b0;
            end
        end
        else if (off_done)
        begin
            step.entry.repeats = rep_dec;
            if (relight)
            begin
                step.entry.lit   = 1'b1;
                step.entry.start = start_off;
                step.report      = 1'b1;
                step.drive_on    = 1'b1;
            end
            else
            begin
                step.keep = 1'b0;
            end
        end
    end

endmodule

// ===== hdl/led_blink_event_table_core.sv =====
// led blink event table: top level with request sequencer and result buffer
// sequence: each stored entry is read in S_READ and handled in S_EXEC via the single
// read port of the entry ram, then S_DONE and S_EMIT follow; a rejected setup or
// unknown request skips the walk; results leave in S_EMIT, one per cycle while
// out_ready is high; throughput: one request at a time, next request accepted after its last result
// reset: asynchronous active low, table empty, tick counter zero, ram left unwritten
module led_blink_event_table_core #(
    parameter int MAX_EVENTS = lbet_pkg::MAX_EVENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  led_id,
    input  logic [15:0] on_time,
    input  logic [15:0] off_time,
    input  logic [7:0]  repeat_count,
    input  logic [7:0]  priority_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  drive_id,
    output logic        drive_valid,
    output logic        drive_on,
    output logic        busy_res,
    output logic        last
);

    localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CNT_W = $clog2(MAX_EVENTS + 1);
    localparam int RES_IDX_W = lbet_pkg::RES_IDX_W;
    localparam int RES_CNT_W = lbet_pkg::RES_CNT_W;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EXEC = 5'b00100,
        S_DONE = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    // one buffered result transaction
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] id;
        logic       drive_valid;
        logic       drive_on;
    } res_t;

    state_t state_reg, state_next;

    // captured request
    logic [1:0]  req_reg, req_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] on_reg, on_next;
    logic [15:0] off_reg, off_next;
    logic [7:0]  rep_reg, rep_next;
    logic [7:0]  prio_reg, prio_next;

    // table state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      now_reg, now_next;

    // walk pointers: r reads every entry, w packs the kept ones
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] hit_pos_reg, hit_pos_next;
    logic [7:0]       hit_prio_reg, hit_prio_next;

    // result buffer
    res_t                 res_buf [lbet_pkg::MAX_RESULTS];
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic [RES_IDX_W-1:0] op_reg, op_next;
    logic                 push;
    res_t                 push_rec;

    // entry ram ports
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    lbet_pkg::entry_t wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    lbet_pkg::entry_t rd_data;

    lbet_pkg::step_t  step;
    lbet_pkg::entry_t new_entry;
    logic             setup_bad;
    logic             id_hit;
    logic             push_room;

    lbet_entry_ram #(
        .DEPTH  (MAX_EVENTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // timing update of the entry just read, against the advanced tick count
    lbet_entry_step u_step (
        .entry (rd_data),
        .now   (now_reg),
        .step  (step)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign status      = res_buf[op_reg].status;
    assign drive_id    = res_buf[op_reg].id;
    assign drive_valid = res_buf[op_reg].drive_valid;
    assign drive_on    = res_buf[op_reg].drive_on;
    // busy reflects the table after the whole request, so results wait in the buffer
    assign busy_res  = (count_reg != '0);
    assign last      = (RES_CNT_W'(op_reg) == n_reg - RES_CNT_W'(1));

    assign setup_bad = (on_reg == 16'd0) || (rep_reg == 8'd0);
    assign id_hit    = (rd_data.id == id_reg);
    assign push_room = (n_reg != RES_CNT_W'(lbet_pkg::MAX_RESULTS));

    always_comb
    begin
        new_entry          = '0;
        new_entry.id       = id_reg;
        new_entry.on_time  = on_reg;
        new_entry.off_time = off_reg;
        new_entry.repeats  = rep_reg;
        new_entry.prio     = prio_reg;
        new_entry.start    = now_reg;
        new_entry.lit      = 1'b1;
    end

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        id_next       = id_reg;
        on_next       = on_reg;
        off_next      = off_reg;
        rep_next      = rep_reg;
        prio_next     = prio_reg;
        count_next    = count_reg;
        now_next      = now_reg;
        r_next        = r_reg;
        w_next        = w_reg;
        found_next    = found_reg;
        hit_pos_next  = hit_pos_reg;
        hit_prio_next = hit_prio_reg;
        n_next        = n_reg;
        op_next       = op_reg;
        push          = 1'b0;
        push_rec      = '0;
        wr_en         = 1'b0;
        wr_addr       = w_reg[IDX_W-1:0];
        wr_data       = rd_data;
        rd_en         = 1'b0;
        rd_addr       = r_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_type;
                    id_next    = led_id;
                    on_next    = on_time;
                    off_next   = off_time;
                    rep_next   = repeat_count;
                    prio_next  = priority_req;
                    r_next     = '0;
                    w_next     = '0;
                    found_next = 1'b0;
                    n_next     = '0;
                    op_next    = '0;
                    if (req_type == lbet_pkg::REQ_TICK)
                    begin
                        now_next = now_reg + 32'd1;
                    end
                    // rejected setups and unknown codes skip the table walk
                    if ((req_type == lbet_pkg::REQ_SETUP &&
                         (on_time == 16'd0 || repeat_count == 8'd0)) ||
                        (req_type != lbet_pkg::REQ_SETUP &&
                         req_type != lbet_pkg::REQ_CANCEL &&
                         req_type != lbet_pkg::REQ_TICK))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                if (r_reg == count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                r_next     = r_reg + CNT_W'(1);
                state_next = S_READ;
                case (req_reg)
                    lbet_pkg::REQ_SETUP:
                    begin
                        if (!found_reg && id_hit)
                        begin
                            found_next    = 1'b1;
                            hit_pos_next  = r_reg[IDX_W-1:0];
                            hit_prio_next = rd_data.prio;
                        end
                    end
                    lbet_pkg::REQ_CANCEL:
                    begin
                        // matching entry is skipped, the rest pack down
                        if (!found_reg && id_hit)
                        begin
                            found_next = 1'b1;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_data = rd_data;
                            w_next  = w_reg + CNT_W'(1);
                        end
                    end
                    lbet_pkg::REQ_TICK:
                    begin
                        if (step.keep)
                        begin
                            wr_en   = 1'b1;
                            wr_data = step.entry;
                            w_next  = w_reg + CNT_W'(1);
                        end
                        if (step.report)
                        begin
                            push                 = push_room;
                            push_rec.status      = lbet_pkg::ST_OK;
                            push_rec.id          = rd_data.id;
                            push_rec.drive_valid = 1'b1;
                            push_rec.drive_on    = step.drive_on;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_DONE:
            begin
                state_next = S_EMIT;
                push       = 1'b1;
                case (req_reg)
                    lbet_pkg::REQ_SETUP:
                    begin
                        if (setup_bad)
                        begin
                            push_rec.status = lbet_pkg::ST_BAD_PARAM;
                        end
                        else if (!found_reg)
                        begin
                            if (count_reg == CNT_W'(MAX_EVENTS))
                            begin
                                push_rec.status = lbet_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en                = 1'b1;
                                wr_addr              = count_reg[IDX_W-1:0];
                                wr_data              = new_entry;
                                count_next           = count_reg + CNT_W'(1);
                                push_rec.status      = lbet_pkg::ST_OK;
                                push_rec.id          = id_reg;
                                push_rec.drive_valid = 1'b1;
                                push_rec.drive_on    = 1'b1;
                            end
                        end
                        else if (hit_prio_reg > prio_reg)
                        begin
                            push_rec.status = lbet_pkg::ST_PRIO_HELD;
                        end
                        else
                        begin
                            // rewrite in place, table position unchanged
                            wr_en                = 1'b1;
                            wr_addr              = hit_pos_reg;
                            wr_data              = new_entry;
                            push_rec.status      = lbet_pkg::ST_OK;
                            push_rec.id          = id_reg;
                            push_rec.drive_valid = 1'b1;
                            push_rec.drive_on    = 1'b1;
                        end
                    end
                    lbet_pkg::REQ_CANCEL:
                    begin
                        // led goes dark even when the id is unknown
                        count_next           = w_reg;
                        push_rec.status      = found_reg ? lbet_pkg::ST_OK
                                                         : lbet_pkg::ST_NOT_FOUND;
                        push_rec.id          = id_reg;
                        push_rec.drive_valid = 1'b1;
                        push_rec.drive_on    = 1'b0;
                    end
                    lbet_pkg::REQ_TICK:
                    begin
                        count_next = w_reg;
                        // quiet tick still gives one transaction
                        push       = (n_reg == '0);
                    end
                    default:
                    begin
                        push_rec.status = lbet_pkg::ST_BAD_PARAM;
                    end
                endcase
            end

            S_EMIT:
            begin
                if (out_ready)
                begin
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        op_next = op_reg + RES_IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (push)
        begin
            n_next = n_reg + RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            now_reg   <= '0;
            r_reg     <= '0;
            w_reg     <= '0;
            found_reg <= 1'b0;
            n_reg     <= '0;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            now_reg   <= now_next;
            r_reg     <= r_next;
            w_reg     <= w_next;
            found_reg <= found_next;
            n_reg     <= n_next;
            op_reg    <= op_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        id_reg       <= id_next;
        on_reg       <= on_next;
        off_reg      <= off_next;
        rep_reg      <= rep_next;
        prio_reg     <= prio_next;
        hit_pos_reg  <= hit_pos_next;
        hit_prio_reg <= hit_prio_next;
        if (push)
        begin
            res_buf[n_reg[RES_IDX_W-1:0]] <= push_rec;
        end
    end

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the led blink event table core
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_LEDS = lbet_pkg::MAX_EVENTS_DEF;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    // long enough to cover the walk of a full table, so this is ample
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT = 40;
    localparam int CALM_FROM = 90;
    localparam int CALM_TO = 140;
    localparam int IDLE_PCT = 21;
    localparam int RANDOM_ITEMS = 186;

    // one request as queued for the driver
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [15:0] on_ticks;
        logic [15:0] off_ticks;
        logic [7:0]  reps;
        logic [7:0]  prio;
        logic        wait_drain;
    } blink_req_t;

    // one response beat as the block should report it
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] drive_id;
        logic       drive_valid;
        logic       drive_on;
        logic       busy;
        logic       last;
    } blink_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    logic [7:0]  led_id = '0;
    logic [15:0] on_time = '0;
    logic [15:0] off_time = '0;
    logic [7:0]  repeat_count = '0;
    logic [7:0]  priority_req = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [7:0]  drive_id;
    logic        drive_valid;
    logic        drive_on;
    logic        busy_res;
    logic        last;

    blink_req_t pending_q[$];
    blink_res_t drive_exp_q[$];

    int accepted_cnt = 0;
    int result_cnt = 0;
    int mismatch_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    // stretch of transactions where neither side idles
    wire calm = (accepted_cnt >= CALM_FROM) && (accepted_cnt < CALM_TO);

    led_blink_event_table_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .led_id       (led_id),
        .on_time      (on_time),
        .off_time     (off_time),
        .repeat_count (repeat_count),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .drive_id     (drive_id),
        .drive_valid  (drive_valid),
        .drive_on     (drive_on),
        .busy_res     (busy_res),
        .last         (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // shadow copy of the event table, in insertion order
    // ------------------------------------------------------------------
    logic [7:0]  tbl_id    [MAX_LEDS];
    logic [15:0] tbl_on    [MAX_LEDS];
    logic [15:0] tbl_off   [MAX_LEDS];
    logic [7:0]  tbl_reps  [MAX_LEDS];
    logic [7:0]  tbl_prio  [MAX_LEDS];
    logic [31:0] tbl_start [MAX_LEDS];
    logic        tbl_lit   [MAX_LEDS];
    int          tbl_count = 0;
    logic [31:0] tick_now = '0;

    function automatic int find_led(logic [7:0] id);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    // remove one entry and close the gap behind it
    function automatic void drop_led(int pos);
        for (int i = pos; i + 1 < tbl_count; i++)
        begin
            tbl_id[i]    = tbl_id[i + 1];
            tbl_on[i]    = tbl_on[i + 1];
            tbl_off[i]   = tbl_off[i + 1];
            tbl_reps[i]  = tbl_reps[i + 1];
            tbl_prio[i]  = tbl_prio[i + 1];
            tbl_start[i] = tbl_start[i + 1];
            tbl_lit[i]   = tbl_lit[i + 1];
        end
        tbl_count--;
    endfunction

    function automatic blink_res_t drive_beat(logic [2:0] st, logic [7:0] id,
                                              logic dv, logic on);
        blink_res_t b;
        b = '0;
        b.status = st;
        b.drive_id = id;
        b.drive_valid = dv;
        b.drive_on = on;
        return b;
    endfunction

    // apply one accepted request to the shadow table and queue its beats
    function automatic void predict_blink(blink_req_t r);
        blink_res_t beats[$];
        blink_res_t b;
        int slot;
        int i;
        logic [31:0] elapsed;
        bit relight;
        case (r.kind)
            lbet_pkg::REQ_SETUP:
            begin
                slot = find_led(r.id);
                if (r.on_ticks == 0 || r.reps == 0)
                    beats.push_back(drive_beat(lbet_pkg::ST_BAD_PARAM, 8'd0, 1'b0, 1'b0));
                else if (slot < 0 && tbl_count >= MAX_LEDS)
                    beats.push_back(drive_beat(lbet_pkg::ST_FULL, 8'd0, 1'b0, 1'b0));
                else if (slot >= 0 && tbl_prio[slot] > r.prio)
                    beats.push_back(drive_beat(lbet_pkg::ST_PRIO_HELD, 8'd0, 1'b0, 1'b0));
                else
                begin
                    // an existing entry keeps its position in the table
                    if (slot < 0)
                    begin
                        slot = tbl_count;
                        tbl_count++;
                    end
                    tbl_id[slot]    = r.id;
                    tbl_on[slot]    = r.on_ticks;
                    tbl_off[slot]   = r.off_ticks;
                    tbl_reps[slot]  = r.reps;
                    tbl_prio[slot]  = r.prio;
                    tbl_start[slot] = tick_now;
                    tbl_lit[slot]   = 1'b1;
                    beats.push_back(drive_beat(lbet_pkg::ST_OK, r.id, 1'b1, 1'b1));
                end
            end
            lbet_pkg::REQ_CANCEL:
            begin
                // the led is driven dark even when no entry exists
                slot = find_led(r.id);
                if (slot >= 0)
                    drop_led(slot);
                beats.push_back(drive_beat(slot >= 0 ? lbet_pkg::ST_OK
                                                     : lbet_pkg::ST_NOT_FOUND,
                                           r.id, 1'b1, 1'b0));
            end
            lbet_pkg::REQ_TICK:
            begin
                tick_now = tick_now + 32'd1;
                i = 0;
                while (i < tbl_count)
                begin
                    elapsed = tick_now - tbl_start[i];
                    if (tbl_lit[i])
                    begin
                        if (elapsed > 32'(tbl_on[i]))
                        begin
                            tbl_lit[i] = 1'b0;
                            tbl_start[i] = tbl_start[i] + 32'(tbl_on[i]);
                            if (beats.size() < lbet_pkg::MAX_RESULTS)
                                beats.push_back(drive_beat(lbet_pkg::ST_OK, tbl_id[i],
                                                           1'b1, 1'b0));
                        end
                    end
                    else if (elapsed > 32'(tbl_off[i]))
                    begin
                        relight = 1'b1;
                        if (tbl_reps[i] != lbet_pkg::FOREVER_REPEATS)
                        begin
                            tbl_reps[i] = tbl_reps[i] - 8'd1;
                            relight = (tbl_reps[i] != 0);
                        end
                        if (relight)
                        begin
                            tbl_lit[i] = 1'b1;
                            tbl_start[i] = tbl_start[i] + 32'(tbl_off[i]);
                            if (beats.size() < lbet_pkg::MAX_RESULTS)
                                beats.push_back(drive_beat(lbet_pkg::ST_OK, tbl_id[i],
                                                           1'b1, 1'b1));
                        end
                        else
                        begin
                            // finished entry leaves silently, its led is already dark
                            drop_led(i);
                            continue;
                        end
                    end
                    i++;
                end
                if (beats.size() == 0)
                    beats.push_back(drive_beat(lbet_pkg::ST_OK, 8'd0, 1'b0, 1'b0));
            end
            default:
                beats.push_back(drive_beat(lbet_pkg::ST_BAD_PARAM, 8'd0, 1'b0, 1'b0));
        endcase
        // busy reflects the table after the request, last marks the final beat
        for (int k = 0; k < beats.size(); k++)
        begin
            b = beats[k];
            b.busy = (tbl_count != 0);
            b.last = (k == beats.size() - 1);
            drive_exp_q.push_back(b);
        end
    endfunction

    // ------------------------------------------------------------------
    // driver: request channel
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        blink_req_t acc;
        blink_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                acc = '0;
                acc.kind = req_type;
                acc.id = led_id;
                acc.on_ticks = on_time;
                acc.off_ticks = off_time;
                acc.reps = repeat_count;
                acc.prio = priority_req;
                predict_blink(acc);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_valid || in_ready)
            begin
                // a marked request waits until every expected beat has arrived
                if (pending_q.size() != 0
                    && !(pending_q[0].wait_drain && drive_exp_q.size() != 0)
                    && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_q.pop_front();
                    in_valid     <= 1'b1;
                    req_type     <= nxt.kind;
                    led_id       <= nxt.id;
                    on_time      <= nxt.on_ticks;
                    off_time     <= nxt.off_ticks;
                    repeat_count <= nxt.reps;
                    priority_req <= nxt.prio;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls plus one long hold-off that backs up the block
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // monitor: compare each response transaction with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_monitor
        blink_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (drive_exp_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat status %0d id %0d",
                                          status, drive_id));
            end
            else
            begin
                e = drive_exp_q.pop_front();
                if (status !== e.status)
                    report_mismatch($sformatf("beat %0d status: exp %0d got %0d",
                                              result_cnt, e.status, status));
                if (drive_id !== e.drive_id)
                    report_mismatch($sformatf("beat %0d drive_id: exp %0d got %0d",
                                              result_cnt, e.drive_id, drive_id));
                if (drive_valid !== e.drive_valid)
                    report_mismatch($sformatf("beat %0d drive_valid: exp %0d got %0d",
                                              result_cnt, e.drive_valid, drive_valid));
                if (drive_on !== e.drive_on)
                    report_mismatch($sformatf("beat %0d drive_on: exp %0d got %0d",
                                              result_cnt, e.drive_on, drive_on));
                if (busy_res !== e.busy)
                    report_mismatch($sformatf("beat %0d busy_res: exp %0d got %0d",
                                              result_cnt, e.busy, busy_res));
                if (last !== e.last)
                    report_mismatch($sformatf("beat %0d last: exp %0d got %0d",
                                              result_cnt, e.last, last));
            end
            result_cnt <= result_cnt + 1;
        end
    end

    function automatic void add_req(logic [1:0] kind, logic [7:0] id, logic [15:0] on_t,
                                    logic [15:0] off_t, logic [7:0] reps,
                                    logic [7:0] prio, logic wait_drain);
        blink_req_t r;
        r.kind = kind;
        r.id = id;
        r.on_ticks = on_t;
        r.off_ticks = off_t;
        r.reps = reps;
        r.prio = prio;
        r.wait_drain = wait_drain;
        pending_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // stimulus and end of test
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        blink_req_t r;
        int roll;
        logic [7:0] stray_id;
        stray_id = 8'd200;

        // directed: empty tick, parameter rejects, field extremes
        add_req(lbet_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0);
        add_req(lbet_pkg::REQ_SETUP, 8'd5, 16'd0, 16'd3, 8'd2, 8'd1, 1'b0);
        add_req(lbet_pkg::REQ_SETUP, 8'd5, 16'd3, 16'd3, 8'd0, 8'd1, 1'b0);
        add_req(lbet_pkg::REQ_SETUP, 8'hFF, 16'hFFFF, 16'hFFFF,
                lbet_pkg::FOREVER_REPEATS, 8'hFF, 1'b0);
        // lower priority is refused, equal priority overwrites in place
        add_req(lbet_pkg::REQ_SETUP, 8'hFF, 16'd1, 16'd1, 8'd2, 8'hFE, 1'b0);
        add_req(lbet_pkg::REQ_SETUP, 8'hFF, 16'd1, 16'd1, 8'd2, 8'hFF, 1'b0);
        // cancel of an id never set up, then an undefined request code
        add_req(lbet_pkg::REQ_CANCEL, 8'd77, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0);
        add_req(REQ_UNKNOWN, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
        // fill the table, all with one-tick phases so a tick hits every entry
        for (int k = 0; k < MAX_LEDS - 1; k++)
            add_req(lbet_pkg::REQ_SETUP, 8'(k), 16'd1, 16'd1,
                    (k == 3) ? lbet_pkg::FOREVER_REPEATS : 8'((k % 2) + 1), 8'(k), 1'b0);
        add_req(lbet_pkg::REQ_SETUP, 8'd100, 16'd2, 16'd2, 8'd1, 8'd0, 1'b0);
        // ticks: all go dark together, relight, finish and leave the table
        for (int k = 0; k < 6; k++)
            add_req(lbet_pkg::REQ_TICK, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0);
        add_req(lbet_pkg::REQ_CANCEL, 8'hFF, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0);
        add_req(lbet_pkg::REQ_CANCEL, 8'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b0);

        // random: mostly ticks and setups on a small id pool, some noise
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            roll = $urandom_range(99);
            r.kind = lbet_pkg::REQ_TICK;
            r.id = 8'($urandom_range(11));
            r.on_ticks = 16'($urandom_range(4, 1));
            r.off_ticks = 16'($urandom_range(4));
            r.reps = ($urandom_range(9) == 0) ? lbet_pkg::FOREVER_REPEATS
                                              : 8'($urandom_range(3, 1));
            r.prio = 8'($urandom_range(3));
            if (roll < 45)
                r.kind = lbet_pkg::REQ_TICK;
            else if (roll < 75)
                r.kind = lbet_pkg::REQ_SETUP;
            else if (roll < 88)
            begin
                r.kind = lbet_pkg::REQ_CANCEL;
                if ($urandom_range(2) == 0)
                    r.id = stray_id;
            end
            else if (roll < 93)
            begin
                // full-range fields so every bit toggles
                r.kind = 2'($urandom_range(3));
                r.id = 8'($urandom);
                r.on_ticks = 16'($urandom);
                r.off_ticks = 16'($urandom);
                r.reps = 8'($urandom);
                r.prio = 8'($urandom);
                stray_id = r.id;
            end
            else if (roll < 96)
            begin
                r.kind = lbet_pkg::REQ_SETUP;
                if ($urandom_range(1) == 0)
                    r.on_ticks = 16'd0;
                else
                    r.reps = 8'd0;
            end
            else
                r.kind = REQ_UNKNOWN;
            // two points where the sender lets the block drain completely
            r.wait_drain = (k == 0) || (k == 120);
            pending_q.push_back(r);
        end

        @(posedge rst_n);
        while (pending_q.size() != 0 || in_valid || drive_exp_q.size() != 0)
            @(posedge clk);
        // let any stray beat show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== led_blink_event_table_core.f =====
hdl/lbet_pkg.sv
hdl/lbet_entry_ram.sv
hdl/lbet_entry_step.sv
hdl/led_blink_event_table_core.sv
bench/testbench.sv
